// File: rtl/rafir_pkg.sv
// Shared types, constants and fixed-point helpers of the RLS adaptive FIR filter.
`default_nettype none

package rafir_pkg;

  localparam int TAPS      = 30;
  localparam int FRAC_BITS = 24;

  localparam int IDX_W     = $clog2(TAPS);
  localparam int MEM_DEPTH = TAPS * TAPS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int WIDE_W = 72;
  localparam int ACC_W  = 56;
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;
  localparam int DEN_W  = 40;
  localparam int NUM_W  = 2 * FRAC_BITS + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int FF_W       = 16;
  localparam int FINV_W     = 18;
  localparam int DELTA_W    = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_FORGET_FACTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET_INVERSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SCALE     = 2'd2;

  localparam logic [FF_W-1:0]    FORGET_FACTOR_RST  = 16'd58982;
  localparam logic [FINV_W-1:0]  FORGET_INVERSE_RST = 18'd72818;
  localparam logic [DELTA_W-1:0] INIT_SCALE_RST     = 25'd5793;

  localparam logic OP_FILTER  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [31:0]       qf_t;
  typedef logic signed [15:0]       smp_t;

  localparam qf_t  QF_MAX  = 32'sh7fffffff;
  localparam qf_t  QF_MIN  = -32'sh7fffffff - 32'sh1;
  localparam smp_t SMP_MAX = 16'sh7fff;
  localparam smp_t SMP_MIN = -16'sh7fff - 16'sh1;

  // Round half up, then shift arithmetically.
  function automatic wide_t rnd(wide_t v, int unsigned s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic qf_t sat32(wide_t v);
    if (v > wide_t'(QF_MAX)) return QF_MAX;
    if (v < wide_t'(QF_MIN)) return QF_MIN;
    return qf_t'(v);
  endfunction

  function automatic smp_t sat16(wide_t v);
    if (v > wide_t'(SMP_MAX)) return SMP_MAX;
    if (v < wide_t'(SMP_MIN)) return SMP_MIN;
    return smp_t'(v);
  endfunction

endpackage

`default_nettype wire

// File: rtl/rafir_if.sv
// Valid/ready channel interfaces for sample items and result items.
`default_nettype none

interface rafir_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [15:0] sample;
  logic signed [15:0] desired;
  logic              adapt_enable;

  modport source (output valid, op, sample, desired, adapt_enable, input ready);
  modport sink   (input valid, op, sample, desired, adapt_enable, output ready);
endinterface

interface rafir_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] error_out;
  logic              adapted;

  modport source (output valid, error_out, adapted, input ready);
  modport sink   (input valid, error_out, adapted, output ready);
endinterface

`default_nettype wire

// File: rtl/rafir_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module rafir_mul import rafir_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

// File: rtl/rafir_div.sv
// Restoring divider that forms the rounded, saturated reciprocal 2^(2F)/den, one bit a cycle.
`default_nettype none

module rafir_div import rafir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output qf_t              quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign quot_o = (quo_q > NUM_W'(QF_MAX)) ? QF_MAX : qf_t'(quo_q[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(den_i >> 1);
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/rls_adaptive_fir_filter_top.sv
// Top level of the RLS adaptive FIR filter: sequencer, matrix memory and state.
// A filter item without update runs the error pass alone; with the RLS update it also
// uses the shared multiplier and the divider (two 900-entry matrix-vector passes, the
// 465-element update of S through S_E0 to S_ENEXT, S_E4 skipped on the diagonal).
// The block takes one item at a time; ready is high only while it is idle.
// A restart item runs a clearing pass over all 900 entries of S; the same pass runs after
// reset, so the block accepts its first item only once that pass is done.
`default_nettype none

module rls_adaptive_fir_filter_top import rafir_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rafir_in_if.sink              in_if,
  rafir_out_if.source           out_if
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ERR, S_MV, S_DOT, S_DIV, S_GROW, S_GROW2,
    S_E0, S_E1, S_E2, S_E3, S_E4, S_ENEXT, S_WUPD, S_WUPD2, S_FIN
  } state_e;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TAPS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

  // Configuration registers.
  logic [FF_W-1:0]    ff_q;
  logic [FINV_W-1:0]  finv_q;
  logic [DELTA_W-1:0] delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q    <= FORGET_FACTOR_RST;
      finv_q  <= FORGET_INVERSE_RST;
      delta_q <= INIT_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORGET_FACTOR:  ff_q    <= cfg_data_i[FF_W-1:0];
        CFG_FORGET_INVERSE: finv_q  <= cfg_data_i[FINV_W-1:0];
        CFG_INIT_SCALE:     delta_q <= cfg_data_i[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter state.
  state_e             state_q;
  smp_t               taps_q    [TAPS];
  qf_t                weights_q [TAPS];
  qf_t                gain_q    [TAPS];
  qf_t                mem       [MEM_DEPTH];
  qf_t                rdata_q;

  logic [ADDR_W-1:0]  k_q;
  logic [IDX_W-1:0]   i_q, j_q;
  logic               iss_q, mv2_q, clr_reply_q, adapt_q;
  logic [DELTA_W-1:0] clr_val_q;
  smp_t               des_q;
  logic signed [ACC_W-1:0] acc_q;
  qf_t                err_q, phi_q, g_q, diff_q, nv_q;
  smp_t               err_res_q;
  logic               adapt_res_q;
  logic [DEN_W-1:0]   den_q;
  logic               div_start_q;

  // Read pipeline tags of the matrix-vector pass and the product stage.
  logic               r_v_q, r_last_q;
  logic [IDX_W-1:0]   r_i_q, r_j_q;
  logic               pv_q, p_last_q;
  logic [IDX_W-1:0]   p_idx_q;

  // Output register.
  logic               out_valid_q;
  smp_t               out_err_q;
  logic               out_adapt_q;

  // Shared units.
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     mul_v, mul_last;
  logic [IDX_W-1:0]         mul_idx;
  logic                     div_done;
  qf_t                      div_quot;

  rafir_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rafir_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Single read points of the small register files.
  logic [IDX_W-1:0]  tidx, gidx;
  smp_t              tap_rd;
  qf_t               gain_rd;
  logic              rd_en, mem_we;
  logic [ADDR_W-1:0] rd_addr, mem_wa, addr_ij, addr_ji;
  qf_t               mem_wd, nv_w;
  logic signed [ACC_W-1:0] acc_sum;
  wide_t             err_full, den_w;

  assign tap_rd  = taps_q[tidx];
  assign gain_rd = gain_q[gidx];
  assign addr_ij = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(TAPS)) + ADDR_W'(j_q);
  assign addr_ji = ADDR_W'(ADDR_W'(j_q) * ADDR_W'(TAPS)) + ADDR_W'(i_q);
  assign acc_sum = acc_q + ACC_W'(prod);
  assign nv_w    = sat32(rnd(wide_t'(prod), 16));
  assign err_full = (wide_t'(des_q) <<< FRAC_BITS) - wide_t'(acc_sum);
  assign den_w   = (wide_t'(ff_q) <<< (FRAC_BITS - 16)) + rnd(wide_t'(acc_sum), 15);

  // Operand selection for the multiplier and the memory ports.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_v    = 1'b0;
    mul_last = 1'b0;
    mul_idx  = i_q;
    tidx     = i_q;
    gidx     = i_q;
    rd_en    = 1'b0;
    rd_addr  = k_q;
    mem_we   = 1'b0;
    mem_wa   = k_q;
    mem_wd   = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = (i_q == j_q) ? qf_t'(clr_val_q) : '0;
      end
      S_ERR: begin
        mul_a    = OP_W'(weights_q[i_q]);
        mul_b    = OP_W'(tap_rd);
        mul_v    = iss_q;
        mul_last = (i_q == LAST_IDX);
      end
      S_MV: begin
        rd_en    = iss_q;
        tidx     = r_j_q;
        mul_a    = OP_W'(rdata_q);
        mul_b    = OP_W'(tap_rd);
        mul_v    = r_v_q;
        mul_last = r_last_q;
        mul_idx  = r_i_q;
      end
      S_DOT: begin
        mul_a    = OP_W'(gain_rd);
        mul_b    = OP_W'(tap_rd);
        mul_v    = iss_q;
        mul_last = (i_q == LAST_IDX);
      end
      S_GROW: begin
        mul_a = OP_W'(gain_rd);
        mul_b = OP_W'(phi_q);
      end
      S_E0: begin
        rd_en   = 1'b1;
        rd_addr = addr_ij;
        gidx    = j_q;
        mul_a   = OP_W'(g_q);
        mul_b   = OP_W'(gain_rd);
      end
      S_E2: begin
        mul_a = OP_W'(diff_q);
        mul_b = OP_W'(finv_q);
      end
      S_E3: begin
        mem_we = 1'b1;
        mem_wa = addr_ij;
        mem_wd = nv_w;
      end
      S_E4: begin
        mem_we = 1'b1;
        mem_wa = addr_ji;
        mem_wd = nv_q;
      end
      S_WUPD: begin
        mul_a = OP_W'(gain_rd);
        mul_b = OP_W'(err_q);
      end
      default: ;
    endcase
  end

  // Matrix memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Gain scratch has no reset; every update writes it before reading it.
  always_ff @(posedge clk_i) begin
    if (state_q == S_MV && pv_q && p_last_q) begin
      gain_q[p_idx_q] <= sat32(rnd(wide_t'(acc_sum), 15));
    end
  end

  assign in_if.ready      = (state_q == S_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.error_out = out_err_q;
  assign out_if.adapted   = out_adapt_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      iss_q       <= 1'b0;
      mv2_q       <= 1'b0;
      clr_reply_q <= 1'b0;
      clr_val_q   <= INIT_SCALE_RST;
      r_v_q       <= 1'b0;
      pv_q        <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      for (int n = 0; n < TAPS; n++) begin
        taps_q[n]    <= '0;
        weights_q[n] <= '0;
      end
    end else begin
      pv_q        <= mul_v;
      p_last_q    <= mul_last;
      p_idx_q     <= mul_idx;
      r_v_q       <= (state_q == S_MV) && iss_q;
      r_i_q       <= i_q;
      r_j_q       <= j_q;
      r_last_q    <= (j_q == LAST_IDX);
      div_start_q <= 1'b0;
      if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          k_q <= k_q + ADDR_W'(1);
          if (j_q == LAST_IDX) begin
            j_q <= '0;
            i_q <= i_q + IDX_W'(1);
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
          if (k_q == LAST_ADDR) begin
            err_res_q   <= '0;
            adapt_res_q <= 1'b0;
            state_q     <= clr_reply_q ? S_FIN : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_if.valid) begin
            i_q <= '0;
            j_q <= '0;
            k_q <= '0;
            if (in_if.op == OP_RESTART) begin
              for (int n = 0; n < TAPS; n++) begin
                taps_q[n]    <= '0;
                weights_q[n] <= '0;
              end
              clr_val_q   <= delta_q;
              clr_reply_q <= 1'b1;
              state_q     <= S_CLEAR;
            end else begin
              taps_q[0] <= in_if.sample;
              for (int n = 1; n < TAPS; n++) begin
                taps_q[n] <= taps_q[n-1];
              end
              des_q   <= in_if.desired;
              adapt_q <= in_if.adapt_enable;
              acc_q   <= '0;
              iss_q   <= 1'b1;
              state_q <= S_ERR;
            end
          end
        end

        S_ERR: begin
          if (iss_q) begin
            if (i_q == LAST_IDX) iss_q <= 1'b0;
            else                 i_q   <= i_q + IDX_W'(1);
          end
          if (pv_q) begin
            if (p_last_q) begin
              acc_q     <= '0;
              err_res_q <= sat16(rnd(err_full, FRAC_BITS));
              err_q     <= sat32(rnd(err_full, 15));
              i_q       <= '0;
              j_q       <= '0;
              k_q       <= '0;
              if (adapt_q) begin
                mv2_q   <= 1'b0;
                iss_q   <= 1'b1;
                state_q <= S_MV;
              end else begin
                adapt_res_q <= 1'b0;
                state_q     <= S_FIN;
              end
            end else begin
              acc_q <= acc_sum;
            end
          end
        end

        // S times the tap line, row by row, through the read and product stages.
        S_MV: begin
          if (iss_q) begin
            k_q <= k_q + ADDR_W'(1);
            if (j_q == LAST_IDX) begin
              j_q <= '0;
              i_q <= i_q + IDX_W'(1);
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
            if (k_q == LAST_ADDR) iss_q <= 1'b0;
          end
          if (pv_q) begin
            if (p_last_q) begin
              acc_q <= '0;
              if (p_idx_q == LAST_IDX) begin
                i_q <= '0;
                if (mv2_q) begin
                  state_q <= S_WUPD;
                end else begin
                  iss_q   <= 1'b1;
                  state_q <= S_DOT;
                end
              end
            end else begin
              acc_q <= acc_sum;
            end
          end
        end

        S_DOT: begin
          if (iss_q) begin
            if (i_q == LAST_IDX) iss_q <= 1'b0;
            else                 i_q   <= i_q + IDX_W'(1);
          end
          if (pv_q) begin
            if (p_last_q) begin
              acc_q       <= '0;
              den_q       <= (den_w < wide_t'(1)) ? DEN_W'(1) : DEN_W'(den_w);
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end else begin
              acc_q <= acc_sum;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            phi_q   <= div_quot;
            i_q     <= '0;
            state_q <= S_GROW;
          end
        end

        S_GROW:  state_q <= S_GROW2;

        S_GROW2: begin
          g_q     <= sat32(rnd(wide_t'(prod), FRAC_BITS));
          j_q     <= i_q;
          state_q <= S_E0;
        end

        S_E0: state_q <= S_E1;

        S_E1: begin
          diff_q  <= sat32(wide_t'(rdata_q) - rnd(wide_t'(prod), FRAC_BITS));
          state_q <= S_E2;
        end

        S_E2: state_q <= S_E3;

        S_E3: begin
          nv_q    <= nv_w;
          state_q <= (j_q != i_q) ? S_E4 : S_ENEXT;
        end

        S_E4: state_q <= S_ENEXT;

        S_ENEXT: begin
          if (j_q == LAST_IDX) begin
            if (i_q == LAST_IDX) begin
              i_q     <= '0;
              j_q     <= '0;
              k_q     <= '0;
              mv2_q   <= 1'b1;
              iss_q   <= 1'b1;
              state_q <= S_MV;
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= S_GROW;
            end
          end else begin
            j_q     <= j_q + IDX_W'(1);
            state_q <= S_E0;
          end
        end

        S_WUPD: state_q <= S_WUPD2;

        S_WUPD2: begin
          weights_q[i_q] <= sat32(wide_t'(weights_q[i_q]) + rnd(wide_t'(prod), FRAC_BITS));
          if (i_q == LAST_IDX) begin
            adapt_res_q <= 1'b1;
            state_q     <= S_FIN;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= S_WUPD;
          end
        end

        S_FIN: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_err_q   <= err_res_q;
            out_adapt_q <= adapt_res_q;
            clr_reply_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_rls_adaptive_fir_filter_top.sv
// Self-checking testbench of the RLS adaptive FIR filter top level.
`default_nettype none

module tb_rls_adaptive_fir_filter_top;
  import rafir_pkg::*;

  typedef struct {
    logic       op;
    logic [15:0] sample;
    logic [15:0] desired;
    logic       adapt_enable;
  } sample_item_t;

  typedef struct {
    logic [15:0] error_out;
    logic        adapted;
  } filter_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rafir_in_if  in_bus ();
  rafir_out_if out_bus ();

  rls_adaptive_fir_filter_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // Items waiting to be sent, and results predicted but not yet seen.
  sample_item_t   pending_items[$];
  filter_result_t results_due[$];

  // Idling control, changed by the sequencing block between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          drain_each     = 1'b0;
  int unsigned failures       = 0;

  // The predictor's own copy of the registers and of the filter state.
  logic [FF_W-1:0]    lambda_q;
  logic [FINV_W-1:0]  lambda_inv_q;
  logic [DELTA_W-1:0] delta_q;
  int fir_taps[TAPS];
  int fir_weights[TAPS];
  int inv_corr_m[TAPS*TAPS];
  int gain_vec[TAPS];

  // Rescale with round half up; the shift of a signed longint is arithmetic.
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clip_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return -32'sh7fffffff - 1;
    return int'(v);
  endfunction

  function automatic void load_restart_state();
    for (int i = 0; i < TAPS; i++) begin
      fir_taps[i]    = 0;
      fir_weights[i] = 0;
      gain_vec[i]    = 0;
      for (int j = 0; j < TAPS; j++) begin
        inv_corr_m[i*TAPS+j] = (i == j) ? int'({7'd0, delta_q}) : 0;
      end
    end
  endfunction

  // gain_vec = S * x
  function automatic void gain_from_taps();
    longint acc;
    for (int i = 0; i < TAPS; i++) begin
      acc = 0;
      for (int j = 0; j < TAPS; j++) begin
        acc += longint'(inv_corr_m[i*TAPS+j]) * longint'(fir_taps[j]);
      end
      gain_vec[i] = clip_q(round_shift(acc, 15));
    end
  endfunction

  function automatic void rls_adapt(int err_q);
    longint          acc;
    longint          den;
    longint          phi;
    longint unsigned num;
    longint          prod;
    longint          diff;
    int              g;
    int              nv;
    gain_from_taps();
    acc = 0;
    for (int i = 0; i < TAPS; i++) acc += longint'(gain_vec[i]) * longint'(fir_taps[i]);
    den = longint'({48'd0, lambda_q}) * (64'sd1 <<< (FRAC_BITS - 16)) + round_shift(acc, 15);
    // A denominator below one LSB is forced to one LSB, so phi saturates.
    if (den < 1) den = 1;
    num = (64'd1 << (2 * FRAC_BITS)) + (longint'(den) >> 1);
    phi = clip_q(longint'(num / longint'(den)));
    for (int i = 0; i < TAPS; i++) begin
      g = clip_q(round_shift(longint'(gain_vec[i]) * phi, FRAC_BITS));
      for (int j = i; j < TAPS; j++) begin
        prod = round_shift(longint'(g) * longint'(gain_vec[j]), FRAC_BITS);
        diff = clip_q(longint'(inv_corr_m[i*TAPS+j]) - prod);
        nv = clip_q(round_shift(diff * longint'({46'd0, lambda_inv_q}), 16));
        inv_corr_m[i*TAPS+j] = nv;
        inv_corr_m[j*TAPS+i] = nv;
      end
    end
    gain_from_taps();
    for (int i = 0; i < TAPS; i++) begin
      prod = round_shift(longint'(gain_vec[i]) * longint'(err_q), FRAC_BITS);
      fir_weights[i] = clip_q(longint'(fir_weights[i]) + prod);
    end
  endfunction

  function automatic filter_result_t predict_filter(sample_item_t it);
    filter_result_t r;
    longint         acc;
    longint         e;
    longint         e16;
    if (it.op == OP_RESTART) begin
      load_restart_state();
      r.error_out = '0;
      r.adapted   = 1'b0;
      return r;
    end
    for (int i = TAPS - 1; i > 0; i--) fir_taps[i] = fir_taps[i-1];
    fir_taps[0] = int'(signed'(it.sample));
    acc = 0;
    for (int i = 0; i < TAPS; i++) acc += longint'(fir_weights[i]) * longint'(fir_taps[i]);
    e = longint'(signed'(it.desired)) * (64'sd1 <<< FRAC_BITS) - acc;
    e16 = round_shift(e, FRAC_BITS);
    if (e16 > 32767) e16 = 32767;
    if (e16 < -32768) e16 = -32768;
    r.error_out = e16[15:0];
    r.adapted   = it.adapt_enable;
    // The update uses the error rescaled by 15 bits and clipped to 32 bits, finer than error_out.
    if (it.adapt_enable) rls_adapt(clip_q(round_shift(e, 15)));
    return r;
  endfunction

  // Clock and the single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents the next pending item and records each accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    logic         launch;
    sample_item_t nxt;
    if (!rst_ni) begin
      in_bus.valid        <= 1'b0;
      in_bus.op           <= OP_FILTER;
      in_bus.sample       <= '0;
      in_bus.desired      <= '0;
      in_bus.adapt_enable <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        nxt.op           = in_bus.op;
        nxt.sample       = in_bus.sample;
        nxt.desired      = in_bus.desired;
        nxt.adapt_enable = in_bus.adapt_enable;
        results_due.push_back(predict_filter(nxt));
      end
      if (!in_bus.valid || in_bus.ready) begin
        // Under the drain mode the sender holds off while any result is still due.
        launch = (pending_items.size() > 0) && ($urandom_range(99) >= send_idle_pct) &&
                 !(drain_each && (results_due.size() > 0));
        if (launch) begin
          nxt = pending_items.pop_front();
          in_bus.op           <= nxt.op;
          in_bus.sample       <= nxt.sample;
          in_bus.desired      <= nxt.desired;
          in_bus.adapt_enable <= nxt.adapt_enable;
        end
        in_bus.valid <= launch;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (results_due.size() == 0) begin
          $error("result item arrived with nothing expected");
          failures++;
        end else begin
          want = results_due.pop_front();
          if (out_bus.error_out !== want.error_out) begin
            $error("error_out: expected %0d, got %0d", signed'(want.error_out),
                   signed'(out_bus.error_out));
            failures++;
          end
          if (out_bus.adapted !== want.adapted) begin
            $error("adapted: expected %0d, got %0d", want.adapted, out_bus.adapted);
            failures++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_item(logic op, logic [15:0] smp, logic [15:0] des,
                                   logic ad);
    sample_item_t it;
    it.op           = op;
    it.sample       = smp;
    it.desired      = des;
    it.adapt_enable = ad;
    pending_items.push_back(it);
  endfunction

  // Sample values: full range, quieter signals, and the rails.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($signed(16'($urandom)) >>> $urandom_range(6));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a restart followed by an adapting run; the rest is noise.
  task automatic queue_random(int n);
    int left;
    int run;
    left = n;
    while (left > 0) begin
      add_item(OP_RESTART, 16'($urandom), 16'($urandom), 1'($urandom));
      left--;
      run = $urandom_range(4, 14);
      while (run > 0 && left > 0) begin
        if ($urandom_range(99) < 4) begin
          add_item(OP_RESTART, 16'($urandom), 16'($urandom), 1'($urandom));
        end else begin
          add_item(OP_FILTER, pick_value(), pick_value(), $urandom_range(99) < 75);
        end
        run--;
        left--;
      end
    end
  endtask

  // Waits on the falling edge, clear of the clocked blocks, until nothing is pending or due and the block is idle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || results_due.size() != 0 || in_bus.valid
           || !in_bus.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_FORGET_FACTOR:  lambda_q     = data[FF_W-1:0];
      CFG_FORGET_INVERSE: lambda_inv_q = data[FINV_W-1:0];
      CFG_INIT_SCALE:     delta_q      = data[DELTA_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [FF_W-1:0] ff, logic [FINV_W-1:0] finv,
                          logic [DELTA_W-1:0] dlt);
    write_reg(CFG_FORGET_FACTOR, CFG_DATA_W'(ff));
    write_reg(CFG_FORGET_INVERSE, CFG_DATA_W'(finv));
    write_reg(CFG_INIT_SCALE, CFG_DATA_W'(dlt));
  endtask

  // Sequencer: phases of register settings, stimulus and idling patterns.
  initial begin
    logic [FF_W-1:0] ff;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_FORGET_FACTOR;
    cfg_data_i = '0;
    lambda_q     = FORGET_FACTOR_RST;
    lambda_inv_q = FORGET_INVERSE_RST;
    delta_q      = INIT_SCALE_RST;
    load_restart_state();
    @(posedge rst_ni);
    wait_idle();

    // Directed part at the reset settings, with no idling on either side.
    add_item(OP_FILTER, 16'h7fff, 16'h8000, 1'b0);
    add_item(OP_FILTER, 16'h8000, 16'h7fff, 1'b1);
    add_item(OP_FILTER, 16'h7fff, 16'h7fff, 1'b1);
    add_item(OP_FILTER, 16'h0000, 16'h0000, 1'b1);
    add_item(OP_FILTER, 16'h8000, 16'h8000, 1'b1);
    add_item(OP_FILTER, 16'hffff, 16'h0001, 1'b1);
    add_item(OP_FILTER, 16'h7fff, 16'h8000, 1'b1);
    add_item(OP_FILTER, 16'h1234, 16'hedcb, 1'b0);
    // A restart ignores its other fields, however they are set.
    add_item(OP_RESTART, 16'hffff, 16'hffff, 1'b1);
    add_item(OP_FILTER, 16'h0000, 16'h7fff, 1'b1);
    for (int i = 0; i < 8; i++) add_item(OP_FILTER, 16'h7fff, 16'h8000, 1'b1);
    add_item(OP_RESTART, 16'h0000, 16'h0000, 1'b0);
    wait_idle();

    // Inconsistent registers: both used as written, with a delta of 25'h1000000.
    set_regs(16'hffff, 18'h20000, 25'h1000000);
    add_item(OP_RESTART, 16'h0, 16'h0, 1'b0);
    for (int i = 0; i < 5; i++) add_item(OP_FILTER, pick_value(), pick_value(), 1'b1);
    wait_idle();

    // Phase with the sender idling.
    set_regs(16'd65535, 18'd65537, 25'h1000000);
    send_idle_pct = 48;
    queue_random(40);
    wait_idle();

    // Phase with the receiver stalling, smallest lambda and delta.
    set_regs(16'd32768, 18'd131072, 25'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    queue_random(40);
    wait_idle();

    // Phase with light idling on both sides and a random consistent pair.
    ff = 16'($urandom_range(32768, 65535));
    set_regs(ff, 18'((64'd1 << 32) / ff), 25'($urandom_range(1, 16777216)));
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    queue_random(40);
    wait_idle();

    // Phase where the sender waits for every result before the next item.
    set_regs(FORGET_FACTOR_RST, FORGET_INVERSE_RST, INIT_SCALE_RST);
    drain_each     = 1'b1;
    recv_stall_pct = 48;
    queue_random(35);
    wait_idle();

    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, sized well beyond the slowest correct run.
  initial begin
    #(4 * 8_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
